// ===== design/pfr_pkg.sv =====
// Shared types and constants for the proportional font text renderer.
package pfr_pkg;

  localparam int PTR_W      = 18;
  localparam int ROW_BUF_W  = 72;
  localparam int MASK_W     = 64;

  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_CURSOR = 2'd1;
  localparam logic [1:0] FN_DRAW   = 2'd2;
  localparam logic [1:0] FN_UNUSED = 2'd3;

  localparam logic [1:0] CFG_WRAP_EN  = 2'd0;
  localparam logic [1:0] CFG_LINE_HT  = 2'd1;
  localparam logic [1:0] CFG_MARGIN   = 2'd2;
  localparam logic [1:0] CFG_INK      = 2'd3;

  localparam logic [7:0] CODE_NL     = 8'd10;
  localparam logic [7:0] CODE_END    = 8'hFF;
  localparam logic [7:0] XOFF_NEG    = 8'h80;
  localparam logic [7:0] XOFF_BIAS   = 8'd255;
  localparam logic [7:0] LINE_GAP    = 8'd5;
  localparam logic [PTR_W-1:0] FIRST_REC = 18'd4;
  localparam logic [PTR_W-1:0] REC_BYTES = 18'd6;
  localparam logic [2:0] HDR_LAST    = 3'd5;
  localparam logic [11:0] CUR_MAX    = 12'd2047;

  // header byte slots
  localparam logic [2:0] H_CODE  = 3'd0;
  localparam logic [2:0] H_YOFF  = 3'd1;
  localparam logic [2:0] H_W     = 3'd2;
  localparam logic [2:0] H_H     = 3'd3;
  localparam logic [2:0] H_XB    = 3'd4;
  localparam logic [2:0] H_DELTA = 3'd5;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_REC  = 11'b00000000010,
    S_HRD  = 11'b00000000100,
    S_HCAP = 11'b00000001000,
    S_MTCH = 11'b00000010000,
    S_SKIP = 11'b00000100000,
    S_ROW  = 11'b00001000000,
    S_BRD  = 11'b00010000000,
    S_BCAP = 11'b00100000000,
    S_EMIT = 11'b01000000000,
    S_ADV  = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       load;
    logic [3:0] idx;
    logic [2:0] off;
    logic [6:0] cols;
  } row_ctl_t;

endpackage

// ===== design/pfr_font_mem.sv =====
// Font byte memory, one write port and one registered read port.
module pfr_font_mem #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/pfr_row.sv =====
// Glyph row assembler: gathers bitmap bytes and aligns them into a pixel mask.
module pfr_row (
  input  logic                        clk,
  input  pfr_pkg::row_ctl_t           ctl,
  input  logic [7:0]                  byte_in,
  output logic [pfr_pkg::MASK_W-1:0]  mask
);

  logic [pfr_pkg::ROW_BUF_W-1:0] buf_r;
  logic [pfr_pkg::ROW_BUF_W-1:0] shifted;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      buf_r <= '0;
    end else if (ctl.load) begin
      buf_r[pfr_pkg::ROW_BUF_W-1 - 8*ctl.idx -: 8] <= byte_in;
    end
  end

  // first pixel of the row sits `off` bits below the buffer's MSB
  assign shifted = buf_r << ctl.off;

  always_comb begin
    for (int i = 0; i < pfr_pkg::MASK_W; i++) begin
      mask[i] = shifted[pfr_pkg::ROW_BUF_W-1-i] && (i < int'(ctl.cols));
    end
  end

endmodule

// ===== design/proportional_font_text_renderer.sv =====
// Top level: proportional bitmap font text renderer with sequencer and cursor.
//
// Usage: in_* is a stream of commands. Each transfer carries func plus the
// fields of all commands; func 0 writes one font byte, func 1 sets the
// cursor and line start, func 2 draws one character (code 10 is newline).
// out_* is a stream of glyph rows: one transfer per row with its screen
// row, column of mask bit 0, 64-bit ink mask and palette index; tlast
// marks the final row of a glyph. cfg_* writes the four control registers
// (wrap enable, line height, wrap margin, ink colour); the user writes them
// only while idle, which the block does not enforce. Font writes and
// cursor sets are taken without leaving idle. A draw walks the glyph table
// through the single font memory read port: each header record is a record
// check, a read and a capture per header byte and a match step, plus a skip
// step when a packed bitmap is stepped over; each row is a row set-up, a
// read and a capture per bitmap byte touched (at most 9) and an emit; a
// final step advances the cursor. in_tready is low for the whole draw; one
// item is in flight at a time. A finished row waits in the output register;
// if the receiver stalls the sequencer holds in its emit step with the next
// row assembled; the last row may still wait while the next command is taken.
// Reset (synchronous, rst_n low) clears cursor, line start, registers to
// their defaults and the output valid; font memory is not cleared.
module proportional_font_text_renderer #(
  parameter int SCREEN_COLUMNS   = 320,
  parameter int FONT_BYTES       = 16384,
  parameter int MAX_GLYPH_WIDTH  = 64,
  parameter int MAX_GLYPH_HEIGHT = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func[1:0] font_address[15:2] font_byte[23:16] pos_x[35:24]
  // pos_y[47:36] char_code[55:48]
  input  logic [55:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_y[12:0] col_x[25:13] row_mask[89:26] color[97:90] zero pad[103:98]
  output logic [103:0] out_tdata,
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [7:0]   cfg_wdata
);

  localparam int AW = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;
  localparam int PW = pfr_pkg::PTR_W;
  localparam logic [PW-1:0] FONT_END = PW'(FONT_BYTES);
  localparam logic [6:0] MAXW = 7'(MAX_GLYPH_WIDTH);
  localparam logic [6:0] MAXH = 7'(MAX_GLYPH_HEIGHT);
  localparam logic signed [13:0] SCR_COLS = 14'(SCREEN_COLUMNS);

  // input fields
  logic [1:0]  in_func;
  logic [13:0] in_addr;
  logic [7:0]  in_byte;
  logic [11:0] in_x, in_y;
  logic [7:0]  in_code;
  assign in_func = in_tdata[1:0];
  assign in_addr = in_tdata[15:2];
  assign in_byte = in_tdata[23:16];
  assign in_x    = in_tdata[35:24];
  assign in_y    = in_tdata[47:36];
  assign in_code = in_tdata[55:48];

  // config
  logic       wrap_en_r;
  logic [7:0] line_ht_r, margin_r, ink_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_en_r <= 1'b1;
      line_ht_r <= 8'd24;
      margin_r  <= 8'd24;
      ink_r     <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfr_pkg::CFG_WRAP_EN: wrap_en_r <= cfg_wdata[0];
        pfr_pkg::CFG_LINE_HT: line_ht_r <= cfg_wdata;
        pfr_pkg::CFG_MARGIN:  margin_r  <= cfg_wdata;
        pfr_pkg::CFG_INK:     ink_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pfr_pkg::state_t state_r, state_nxt;
  logic [11:0] cx_r, cx_nxt, cy_r, cy_nxt, lsx_r, lsx_nxt;
  logic [PW-1:0] ptr_r, ptr_nxt, baddr_r, baddr_nxt;
  logic [2:0]  hc_r, hc_nxt;
  logic [7:0]  hdr_r [6];
  logic [7:0]  code_r, code_nxt;
  logic [15:0] prod_r;
  logic [6:0]  rows_r, rows_nxt, cols_r, cols_nxt, j_r, j_nxt;
  logic [16:0] kbit_r, kbit_nxt;
  logic [3:0]  nb_r, nb_nxt, bc_r, bc_nxt;
  logic [2:0]  off_r, off_nxt;
  logic        oob_r;
  logic        out_valid_r;
  logic [12:0] out_y_r, out_x_r;
  logic [63:0] out_mask_r;
  logic [7:0]  out_col_r;
  logic        out_last_r;

  // font memory
  logic          mem_we;
  logic [PW-1:0] rd_addr;
  logic [7:0]    mem_q, rd_byte;

  assign mem_we = in_tvalid && in_tready && (in_func == pfr_pkg::FN_WRITE)
                  && ({4'd0, in_addr} < FONT_END);
  assign rd_addr = state_r[$clog2(int'(pfr_pkg::S_BRD))] ? baddr_r + PW'(bc_r)
                                                           : ptr_r + PW'(hc_r);

  pfr_font_mem #(.DEPTH(FONT_BYTES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'({4'd0, in_addr})),
    .wdata (in_byte),
    .raddr (rd_addr[AW-1:0]),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    oob_r <= rd_addr >= FONT_END;
  end
  assign rd_byte = oob_r ? 8'd0 : mem_q;

  // row assembler
  pfr_pkg::row_ctl_t row_ctl;
  logic [63:0] row_mask;
  assign row_ctl.clear = (state_r == pfr_pkg::S_ROW);
  assign row_ctl.load  = (state_r == pfr_pkg::S_BCAP);
  assign row_ctl.idx   = bc_r;
  assign row_ctl.off   = off_r;
  assign row_ctl.cols  = cols_r;

  pfr_row u_row (
    .clk     (clk),
    .ctl     (row_ctl),
    .byte_in (rd_byte),
    .mask    (row_mask)
  );

  // cursor arithmetic
  logic signed [13:0] cx_ext, cy_ext, wrap_lim, y_step, x_step;
  logic               do_wrap;
  logic [7:0]         gw, gh, adv;
  logic [12:0]        xoff;
  logic               out_free;

  assign cx_ext   = $signed({{2{cx_r[11]}}, cx_r});
  assign cy_ext   = $signed({{2{cy_r[11]}}, cy_r});
  assign wrap_lim = SCR_COLS - $signed({6'd0, margin_r});
  assign do_wrap  = (wrap_en_r && (cx_ext >= wrap_lim)) || (in_code == pfr_pkg::CODE_NL);
  assign y_step   = cy_ext + $signed({6'd0, line_ht_r}) + $signed({6'd0, pfr_pkg::LINE_GAP});
  assign gw       = hdr_r[pfr_pkg::H_W];
  assign gh       = hdr_r[pfr_pkg::H_H];
  assign adv      = (gw > hdr_r[pfr_pkg::H_DELTA]) ? gw : hdr_r[pfr_pkg::H_DELTA];
  assign x_step   = cx_ext + $signed({6'd0, adv});
  assign xoff     = (hdr_r[pfr_pkg::H_XB] < pfr_pkg::XOFF_NEG)
                    ? {5'd0, hdr_r[pfr_pkg::H_XB]}
                    : {5'd0, hdr_r[pfr_pkg::H_XB]} - {5'd0, pfr_pkg::XOFF_BIAS};
  assign out_free = !out_valid_r || out_tready;

  assign in_tready = (state_r == pfr_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    lsx_nxt   = lsx_r;
    ptr_nxt   = ptr_r;
    baddr_nxt = baddr_r;
    hc_nxt    = hc_r;
    code_nxt  = code_r;
    rows_nxt  = rows_r;
    cols_nxt  = cols_r;
    j_nxt     = j_r;
    kbit_nxt  = kbit_r;
    nb_nxt    = nb_r;
    bc_nxt    = bc_r;
    off_nxt   = off_r;
    unique case (state_r)
      pfr_pkg::S_IDLE: begin
        if (in_tvalid) begin
          if (in_func == pfr_pkg::FN_CURSOR) begin
            cx_nxt  = in_x;
            lsx_nxt = in_x;
            cy_nxt  = in_y;
          end else if (in_func == pfr_pkg::FN_DRAW) begin
            code_nxt = in_code;
            ptr_nxt  = pfr_pkg::FIRST_REC;
            state_nxt = pfr_pkg::S_REC;
            if (do_wrap) begin
              cx_nxt = lsx_r;
              cy_nxt = (y_step > $signed({2'd0, pfr_pkg::CUR_MAX})) ? pfr_pkg::CUR_MAX
                                                                     : y_step[11:0];
            end
          end
        end
      end
      pfr_pkg::S_REC: begin
        hc_nxt = '0;
        // record must fit inside the font
        state_nxt = (ptr_r + pfr_pkg::REC_BYTES > FONT_END) ? pfr_pkg::S_IDLE
                                                             : pfr_pkg::S_HRD;
      end
      pfr_pkg::S_HRD: state_nxt = pfr_pkg::S_HCAP;
      pfr_pkg::S_HCAP: begin
        if (hc_r == pfr_pkg::HDR_LAST) begin
          state_nxt = pfr_pkg::S_MTCH;
        end else begin
          hc_nxt    = hc_r + 3'd1;
          state_nxt = pfr_pkg::S_HRD;
        end
      end
      pfr_pkg::S_MTCH: begin
        ptr_nxt = ptr_r + pfr_pkg::REC_BYTES;
        hc_nxt  = '0;
        if (hdr_r[pfr_pkg::H_CODE] == code_r) begin
          rows_nxt = ({1'b0, gh} < {2'b0, MAXH}) ? gh[6:0] : MAXH;
          cols_nxt = ({1'b0, gw} < {2'b0, MAXW}) ? gw[6:0] : MAXW;
          j_nxt    = '0;
          kbit_nxt = '0;
          state_nxt = (gh == 8'd0) ? pfr_pkg::S_ADV : pfr_pkg::S_ROW;
        end else if (hdr_r[pfr_pkg::H_CODE] == pfr_pkg::CODE_END) begin
          state_nxt = pfr_pkg::S_IDLE;
        end else if (gw != 8'd0) begin
          state_nxt = pfr_pkg::S_SKIP;
        end else begin
          state_nxt = pfr_pkg::S_REC;
        end
      end
      pfr_pkg::S_SKIP: begin
        // packed bitmap size in bytes, one byte for a zero height
        if (gh == 8'd0) begin
          ptr_nxt = ptr_r + PW'(1);
        end else begin
          ptr_nxt = ptr_r + PW'((prod_r - 16'd1) >> 3) + PW'(1);
        end
        state_nxt = pfr_pkg::S_REC;
      end
      pfr_pkg::S_ROW: begin
        baddr_nxt = ptr_r + PW'(kbit_r >> 3);
        off_nxt   = kbit_r[2:0];
        nb_nxt    = 4'(({7'd0, kbit_r[2:0]} + {3'd0, cols_r} + 10'd7) >> 3);
        bc_nxt    = '0;
        state_nxt = (cols_r == 7'd0) ? pfr_pkg::S_EMIT : pfr_pkg::S_BRD;
      end
      pfr_pkg::S_BRD: state_nxt = pfr_pkg::S_BCAP;
      pfr_pkg::S_BCAP: begin
        if (bc_r + 4'd1 >= nb_r) begin
          state_nxt = pfr_pkg::S_EMIT;
        end else begin
          bc_nxt    = bc_r + 4'd1;
          state_nxt = pfr_pkg::S_BRD;
        end
      end
      pfr_pkg::S_EMIT: begin
        if (out_free) begin
          j_nxt    = j_r + 7'd1;
          kbit_nxt = kbit_r + {9'd0, gw};
          state_nxt = (j_r + 7'd1 == rows_r) ? pfr_pkg::S_ADV : pfr_pkg::S_ROW;
        end
      end
      pfr_pkg::S_ADV: begin
        cx_nxt = (x_step > $signed({2'd0, pfr_pkg::CUR_MAX})) ? pfr_pkg::CUR_MAX
                                                               : x_step[11:0];
        state_nxt = pfr_pkg::S_IDLE;
      end
      default: state_nxt = pfr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfr_pkg::S_IDLE;
      cx_r        <= '0;
      cy_r        <= '0;
      lsx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      lsx_r   <= lsx_nxt;
      if (state_r == pfr_pkg::S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    baddr_r <= baddr_nxt;
    hc_r    <= hc_nxt;
    code_r  <= code_nxt;
    rows_r  <= rows_nxt;
    cols_r  <= cols_nxt;
    j_r     <= j_nxt;
    kbit_r  <= kbit_nxt;
    nb_r    <= nb_nxt;
    bc_r    <= bc_nxt;
    off_r   <= off_nxt;
    if (state_r == pfr_pkg::S_HCAP) begin
      hdr_r[hc_r] <= rd_byte;
    end
    if (state_r == pfr_pkg::S_MTCH) begin
      prod_r <= gw * gh;
    end
    if (state_r == pfr_pkg::S_EMIT && out_free) begin
      out_y_r    <= {cy_r[11], cy_r} + {6'd0, j_r} + {5'd0, hdr_r[pfr_pkg::H_YOFF]};
      out_x_r    <= {cx_r[11], cx_r} + xoff;
      out_mask_r <= row_mask;
      out_col_r  <= ink_r;
      out_last_r <= (j_r + 7'd1 == rows_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_col_r, out_mask_r, out_x_r, out_y_r};

endmodule

// ===== design/pfr_checker.sv =====
// Port-level checker for the text renderer, bound to the top level.
module pfr_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [55:0]  in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tlast
);

  // stalled row holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output row changed");

  // a draw keeps the block busy
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == pfr_pkg::FN_DRAW |=> !in_tready)
    else $error("draw did not occupy the sequencer");

  // a font write leaves the block ready for the next command
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == pfr_pkg::FN_WRITE |=> in_tready)
    else $error("font write did not return to idle");

  // new rows appear only during a draw
  a_row_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready)
    else $error("row produced while idle");

endmodule

bind proportional_font_text_renderer pfr_checker u_pfr_checker (.*);
